@@ design/slirs_pkg.sv @@
// Package for the sorted list unit: field widths, operation and status codes,
// and the command/status structs between controller and datapath.
// Depends on nothing; every other design file uses it by scoped names.
`default_nettype none

package slirs_pkg;

  // Fixed widths of the item fields.
  localparam int unsigned OP_W    = 2;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned POS_W   = 9;
  localparam int unsigned COUNT_W = 9;

  // Default table depth handed to the top level.
  localparam int unsigned DEPTH_DEFAULT = 16;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

  // Status codes.
  localparam logic [STAT_W-1:0] STAT_DONE      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the accepted item and set up the scan
    logic rd;      // issue a table read at the scan address
    logic step;    // read data is back: compare, move an entry, advance
    logic finish;  // commit the count and load the result register
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic more;      // the scan still has an entry to visit
    logic out_free;  // the result register can take a new result
  } ctl_sts_t;

endpackage

`default_nettype wire

@@ design/slirs_if.sv @@
// Handshake channels of the sorted list unit: the request channel and the
// result channel, each with valid, ready and payload. Depends on slirs_pkg.
`default_nettype none

interface slirs_req_if;
  logic                            valid;
  logic                            ready;
  logic [slirs_pkg::OP_W-1:0]      operation;
  logic signed [slirs_pkg::VAL_W-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

interface slirs_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [slirs_pkg::STAT_W-1:0]      status;
  logic [slirs_pkg::POS_W-1:0]       position;
  logic [slirs_pkg::COUNT_W-1:0]     entry_count;

  modport source (output valid, output status, output position, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input position, input entry_count,
                  output ready);
endinterface

`default_nettype wire

@@ design/slirs_ctrl.sv @@
// Controller of the sorted list unit: sequences accept, table scan and
// result hand-off. Depends on slirs_pkg for the command and status structs.
`default_nettype none

module slirs_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_ready,
  input  wire slirs_pkg::ctl_sts_t sts,
  output slirs_pkg::ctl_cmd_t      cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECIDE = 2'd1;
  localparam logic [1:0] S_CHECK  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.more) begin
          cmd.rd     = 1'b1;
          state_next = S_CHECK;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_CHECK: begin
        cmd.step   = 1'b1;
        state_next = S_DECIDE;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

@@ design/slirs_dp.sv @@
// Datapath of the sorted list unit: the entry table memory, scan index,
// entry count and result register. Depends on slirs_pkg and slirs_if.
`default_nettype none

module slirs_dp #(
  parameter int unsigned DEPTH = slirs_pkg::DEPTH_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [slirs_pkg::OP_W-1:0]   req_operation,
  input  wire logic signed [slirs_pkg::VAL_W-1:0] req_value,
  input  wire slirs_pkg::ctl_cmd_t          cmd,
  output slirs_pkg::ctl_sts_t               sts,
  slirs_rsp_if.source                       rsp
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // Entry table; reads are registered.
  logic signed [slirs_pkg::VAL_W-1:0] mem [DEPTH];
  logic signed [slirs_pkg::VAL_W-1:0] rdata;

  logic [slirs_pkg::OP_W-1:0]         op_r;
  logic signed [slirs_pkg::VAL_W-1:0] val_r;
  logic [CW-1:0]                      idx;
  logic [CW-1:0]                      pos;
  logic [CW-1:0]                      count;
  logic                               found;
  logic                               out_valid;
  logic [slirs_pkg::STAT_W-1:0]       out_status;
  logic [slirs_pkg::POS_W-1:0]        out_pos;
  logic [slirs_pkg::COUNT_W-1:0]      out_count;

  logic [CW-1:0]                      idx_m1;
  logic                               is_ins;
  logic                               is_rem;
  logic                               is_srch;
  logic                               full;
  logic                               less;
  logic                               hit;
  logic [AW-1:0]                      raddr;
  logic                               we;
  logic [AW-1:0]                      waddr;
  logic signed [slirs_pkg::VAL_W-1:0] wdata;
  logic [slirs_pkg::STAT_W-1:0]       status_next;
  logic [CW-1:0]                      pos_next;
  logic [CW-1:0]                      count_next;

  // Operation decode and compares against the entry just read.
  always_comb begin
    idx_m1  = idx - CW'(1);
    is_ins  = (op_r == slirs_pkg::OP_INSERT);
    is_rem  = (op_r == slirs_pkg::OP_REMOVE);
    is_srch = (op_r == slirs_pkg::OP_SEARCH);
    full    = (count == CW'(DEPTH));
    less    = (rdata < val_r);
    hit     = (rdata == val_r);
  end

  // Scan continuation. Insert walks down from the top, shifting entries up;
  // remove walks the whole list, shifting entries down past the match;
  // search stops at the first match.
  always_comb begin
    sts.out_free = !out_valid || rsp.ready;
    if (is_ins) begin
      sts.more = !full && !found && (idx != '0);
    end else if (is_rem) begin
      sts.more = (idx < count);
    end else if (is_srch) begin
      sts.more = !found && (idx < count);
    end else begin
      sts.more = 1'b0;
    end
  end

  // Table read address and write port.
  always_comb begin
    raddr = is_ins ? idx_m1[AW-1:0] : idx[AW-1:0];
    we    = 1'b0;
    waddr = idx[AW-1:0];
    wdata = rdata;
    if (cmd.step) begin
      if (is_ins) begin
        we    = 1'b1;
        waddr = idx[AW-1:0];
        wdata = less ? val_r : rdata;
      end else if (is_rem && found) begin
        we    = 1'b1;
        waddr = idx_m1[AW-1:0];
        wdata = rdata;
      end
    end else if (cmd.finish && is_ins && !full && !found) begin
      // The new value is the smallest: it lands at the bottom.
      we    = 1'b1;
      waddr = '0;
      wdata = val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd) begin
      rdata <= mem[raddr];
    end
  end

  // Result of the finished operation.
  always_comb begin
    status_next = slirs_pkg::STAT_NOT_FOUND;
    pos_next    = '0;
    count_next  = count;
    if (is_ins) begin
      if (full) begin
        status_next = slirs_pkg::STAT_FULL;
      end else begin
        status_next = slirs_pkg::STAT_DONE;
        pos_next    = pos;
        count_next  = count + CW'(1);
      end
    end else if ((is_rem || is_srch) && found) begin
      status_next = slirs_pkg::STAT_DONE;
      pos_next    = pos;
      if (is_rem) begin
        count_next = count - CW'(1);
      end
    end
  end

  // Scan registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= req_operation;
      val_r <= req_value;
      found <= 1'b0;
      pos   <= '0;
      idx   <= (req_operation == slirs_pkg::OP_INSERT) ? count : '0;
    end else if (cmd.step) begin
      if (is_ins) begin
        if (less) begin
          found <= 1'b1;
          pos   <= idx;
        end else begin
          idx <= idx_m1;
        end
      end else begin
        if (!found && hit) begin
          found <= 1'b1;
          pos   <= idx;
        end
        idx <= idx + CW'(1);
      end
    end
  end

  // Entry count and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status <= status_next;
      out_pos    <= slirs_pkg::POS_W'(pos_next);
      out_count  <= slirs_pkg::COUNT_W'(count_next);
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.position    = out_pos;
  assign rsp.entry_count = out_count;

endmodule

`default_nettype wire

@@ design/sorted_list_insert_remove_search_unit.sv @@
// Top level of the sorted list unit: joins the controller and the datapath.
// Depends on slirs_pkg, slirs_if, slirs_ctrl and slirs_dp.
//
//   Channel  Dir  Handshake      Payload
//   req      in   valid/ready    operation[1:0], value[31:0] signed
//   rsp      out  valid/ready    status[1:0], position[8:0], entry_count[8:0]
//
// One item at a time. The result register is loaded in the finish state, and the next item
// can be accepted once the controller is back in its idle state. Table entries are read one
// at a time: for insert, the entries above the insertion point plus the entry just below it
// when there is one; for remove, the whole list; for search, the entries up to and
// including the first match. Each read goes through the single table read port with
// registered read data. Reset clears the entry count; the table needs no clearing.
// A result waits in its register while the next item is accepted, and the next result
// is held in the finish state until that register is free.
`default_nettype none

module sorted_list_insert_remove_search_unit #(
  parameter int unsigned DEPTH = slirs_pkg::DEPTH_DEFAULT
) (
  input  wire logic    clk,
  input  wire logic    rst,
  slirs_req_if.sink    req,
  slirs_rsp_if.source  rsp
);

  slirs_pkg::ctl_cmd_t cmd;
  slirs_pkg::ctl_sts_t sts;

  slirs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  slirs_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .req_operation (req.operation),
    .req_value     (req.value),
    .cmd           (cmd),
    .sts           (sts),
    .rsp           (rsp)
  );

endmodule

`default_nettype wire
